// ===== src/compacting_list_engine_assert.svh =====
// assertion macros used by the list engine datapath module
// each macro expects clk and rst_n in scope
`ifndef COMPACTING_LIST_ENGINE_ASSERT_SVH
`define COMPACTING_LIST_ENGINE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CLE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("compacting_list_engine: assertion failed");

// consequence that must hold in the cycle after the antecedent
`define CLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compacting_list_engine: assertion failed");

`endif

// ===== src/cle_pkg.sv =====
`default_nettype none

package cle_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int VALUE_W    = 32;
    localparam int FUNC_W     = 2;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int CAP_W      = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_READ,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;
        logic do_append;
        logic rd_en;
        logic rd_next;
        logic shift_wr;
        logic idx_inc;
        logic mark_hit;
        logic dec_occ;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic at_last;
        logic next_last;
        logic is_delete;
        logic occ_zero;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/compacting_list_engine.sv =====
// channel  handshake            payload
// in       in_valid / in_stall  func, value
// out      out_valid / out_stall found, position, count, empty_res, status
// cfg      cfg_valid / cfg_ready cfg_data (capacity_limit)
//
// one request at a time; append goes through the append and finish states to the result
// find or delete reads and checks each entry in turn from index 0 to the first match or the last
// a delete then moves each later entry down, one memory read and one write each
// rst_n clears the count and sets the capacity to 64, entries are not cleared
// a stalled result holds in the output register; the next request is taken meanwhile
`default_nettype none

module compacting_list_engine
    import cle_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic [POS_W-1:0]               position,
    output logic [COUNT_W-1:0]             count,
    output logic                           empty_res,
    output logic                           status,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CAP_W-1:0]          cfg_data
);

    cmd_t cmd;
    sts_t sts;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    cle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .func      (func),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .found     (found),
        .position  (position),
        .count     (count),
        .empty_res (empty_res),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== src/cle_ctrl.sv =====
`default_nettype none

module cle_ctrl
    import cle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [FUNC_W-1:0] func,
    input  wire sts_t              sts,
    output logic                   in_stall,
    output cmd_t                   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        FUNC_APPEND: state_next = ST_APPEND;
                        FUNC_DELETE,
                        FUNC_FIND:   state_next = sts.occ_zero ? ST_FINISH : ST_READ;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_APPEND:   state_next = ST_FINISH;
            ST_READ:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (sts.match)
                begin
                    state_next = (sts.is_delete && !sts.at_last) ? ST_SHIFT_RD : ST_FINISH;
                end
                else
                begin
                    state_next = sts.at_last ? ST_FINISH : ST_READ;
                end
            end
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = sts.next_last ? ST_FINISH : ST_SHIFT_RD;
            ST_FINISH:   state_next = sts.out_free ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:     cmd.load_req  = in_valid;
            ST_APPEND:   cmd.do_append = 1'b1;
            ST_READ:     cmd.rd_en     = 1'b1;
            ST_CHECK:
            begin
                cmd.mark_hit = sts.match;
                // hit on the last entry needs no shift
                cmd.dec_occ  = sts.match && sts.is_delete && sts.at_last;
                cmd.idx_inc  = !sts.match && !sts.at_last;
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                cmd.dec_occ  = sts.next_last;
            end
            ST_FINISH:   cmd.load_out = sts.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cle_dp.sv =====
`default_nettype none

`include "compacting_list_engine_assert.svh"

module cle_dp
    import cle_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output sts_t                           sts,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CAP_W-1:0]          cfg_data,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic                           found,
    output logic [POS_W-1:0]               position,
    output logic [COUNT_W-1:0]             count,
    output logic                           empty_res,
    output logic                           status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int OCW   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic signed [VALUE_W-1:0] entries_reg [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]          occ_reg;
    logic [CAP_W-1:0]          cap_reg;
    logic                      out_valid_reg;

    logic [FUNC_W-1:0]         op_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      hit_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic                      stat_reg;

    logic                      found_reg;
    logic [POS_W-1:0]          position_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      empty_reg;
    logic                      status_reg;

    logic                      full;
    logic                      mem_we;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic [CNT_W:0]            idx_ext;
    logic [CNT_W:0]            occ_ext;
    logic [OCW-1:0]            occ_out;
    logic [PW-1:0]             pos_out;

    // full when count reached the capacity register or the array depth
    assign full = (CMP_W'(occ_reg) >= CMP_W'(cap_reg)) || (occ_reg >= CNT_W'(DEPTH));

    assign mem_we  = (cmd.do_append && !full) || cmd.shift_wr;
    assign wr_addr = cmd.shift_wr ? idx_reg : occ_reg[IDX_W-1:0];
    assign wr_data = cmd.shift_wr ? rd_data_reg : val_reg;
    assign rd_addr = cmd.rd_next ? (idx_reg + IDX_W'(1)) : idx_reg;

    assign idx_ext = (CNT_W + 1)'(idx_reg);
    assign occ_ext = (CNT_W + 1)'(occ_reg);
    assign occ_out = OCW'(occ_reg);
    assign pos_out = PW'(pos_reg);

    assign sts.match     = (rd_data_reg == val_reg);
    assign sts.at_last   = (idx_ext + (CNT_W + 1)'(1)) >= occ_ext;
    assign sts.next_last = (idx_ext + (CNT_W + 1)'(2)) >= occ_ext;
    assign sts.is_delete = (op_reg == FUNC_DELETE);
    assign sts.occ_zero  = (occ_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.do_append && !full)
            begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
            else if (cmd.dec_occ)
            begin
                occ_reg <= occ_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg   <= func;
            val_reg  <= value;
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            pos_reg  <= '0;
            stat_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_append && full)
            begin
                stat_reg <= 1'b1;
            end
            if (cmd.mark_hit)
            begin
                hit_reg <= 1'b1;
                pos_reg <= idx_reg;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (cmd.load_out)
        begin
            found_reg    <= hit_reg;
            position_reg <= pos_out[POS_W-1:0];
            count_reg    <= occ_out[COUNT_W-1:0];
            empty_reg    <= (occ_reg == '0);
            status_reg   <= stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;
    assign status    = status_reg;

    `CLE_ASSERT(a_occ_bound, occ_reg <= CNT_W'(DEPTH))
    `CLE_ASSERT(a_out_slot, cmd.load_out |-> !(out_valid_reg && out_stall))
    `CLE_ASSERT(a_dec_nonempty, cmd.dec_occ |-> (occ_reg != '0))
    `CLE_ASSERT_NEXT(a_append_grows, cmd.do_append && !full, occ_reg == CNT_W'($past(occ_reg) + CNT_W'(1)))

endmodule

`default_nettype wire
